// ----- sv/msca_pkg.sv -----
// ---------------------------------------------------------------------------
// msca_pkg: shared types and constants of the mixed-sign checked ALU
// Action and error codes, size codes and the back-end state type.
// ---------------------------------------------------------------------------
package msca_pkg;

	localparam int DATA_WIDTH_DEF = 64;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		ACT_CMP  = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_DIV  = 3'd4,
		ACT_NEG  = 3'd5,
		ACT_SIZE = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_LOW     = 3'd1,
		ERR_HIGH    = 3'd2,
		ERR_NEG_OVF = 3'd3,
		ERR_MUL_OVF = 3'd4,
		ERR_DIV0    = 3'd5,
		ERR_QUO_OVF = 3'd6
	} err_t;

	localparam logic [2:0] SZ_8    = 3'd0;
	localparam logic [2:0] SZ_16   = 3'd1;
	localparam logic [2:0] SZ_32   = 3'd2;
	localparam logic [2:0] SZ_64   = 3'd3;
	localparam logic [2:0] SZ_NONE = 3'd4;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

// ----- sv/msca_front.sv -----
// ---------------------------------------------------------------------------
// msca_front: operand load and classification
// Turn raw operands into sign and magnitude; precompute compare, size,
// add/sub/negate results so the back end only handles multiply and divide.
// ---------------------------------------------------------------------------
module msca_front #(
	parameter int W = msca_pkg::DATA_WIDTH_DEF
) (
	input  logic [2:0]    action,
	input  logic [63:0]   a_value,
	input  logic          a_is_signed,
	input  logic [63:0]   b_value,
	input  logic          b_is_signed,
	output logic [2*W+18:0] entry
);
	import msca_pkg::*;

	localparam logic [W:0] SBIT = (W+1)'(1) << (W-1);
	localparam logic [W:0] VMAX = ((W+1)'(1) << W) - (W+1)'(1);

	logic [W-1:0] araw, braw;
	logic         an, bn, bn2;
	logic [W:0]   am, bm;
	logic [W+1:0] sum, dif;
	logic         rn;
	logic [W:0]   rm;
	logic [2:0]   err, ssz, usz;
	logic [1:0]   asz;
	logic         lt, eq, gt;
	logic [W-1:0] rbits;

	function automatic logic [W:0] lim(input int bits);
		if (bits >= W) return VMAX;
		return ((W+1)'(1) << bits) - (W+1)'(1);
	endfunction

	always_comb begin
		araw = a_value[W-1:0];
		braw = b_value[W-1:0];
		an = a_is_signed & araw[W-1];
		bn = b_is_signed & braw[W-1];
		am = an ? {1'b0, -araw} : {1'b0, araw};
		bm = bn ? {1'b0, -braw} : {1'b0, braw};
		if (an && am == '0) am = SBIT;
		if (bn && bm == '0) bm = SBIT;
		// compare
		lt = 1'b0; eq = 1'b0; gt = 1'b0;
		if (an != bn) begin
			lt = an; gt = bn;
		end else if (am == bm) begin
			eq = 1'b1;
		end else begin
			lt = (am < bm) ^ an;
			gt = ~lt;
		end
		// add / subtract with b sign flipped
		bn2 = (action == ACT_SUB && bm != '0) ? ~bn : bn;
		rn = 1'b0; rm = '0; err = ERR_NONE;
		ssz = SZ_8; usz = SZ_8; asz = 2'd0;
		sum = {1'b0, am} + {1'b0, bm};
		dif = {1'b0, am} - {1'b0, bm};
		case (action)
			ACT_ADD, ACT_SUB: begin
				if (an == bn2) begin
					rn = an; rm = sum[W:0];
					if (an ? (sum > {1'b0, SBIT}) : (sum > {1'b0, VMAX}))
						err = an ? ERR_LOW : ERR_HIGH;
				end else if (!dif[W+1]) begin
					rn = an; rm = dif[W:0];
				end else begin
					rn = bn2; rm = -dif[W:0];
				end
				if (rm == '0) rn = 1'b0;
			end
			ACT_NEG: begin
				if (!an && am > SBIT) err = ERR_NEG_OVF;
				else begin
					rm = am; rn = !an && am != '0;
				end
			end
			ACT_SIZE: begin
				ssz = (am <= (an ? lim(7) + 1 : lim(7))) ? SZ_8 :
				      (am <= (an ? lim(15) + 1 : lim(15))) ? SZ_16 :
				      (am <= (an ? lim(31) + 1 : lim(31))) ? SZ_32 :
				      (am <= (an ? lim(63) + 1 : lim(63))) ? SZ_64 : SZ_NONE;
				if (an) begin
					usz = SZ_NONE;
					asz = (am <= lim(7) + 1) ? 2'd0 : (am <= lim(15) + 1) ? 2'd1 :
					      (am <= lim(31) + 1) ? 2'd2 : 2'd3;
				end else begin
					usz = (am <= lim(8)) ? SZ_8 : (am <= lim(16)) ? SZ_16 :
					      (am <= lim(32)) ? SZ_32 : SZ_64;
					asz = usz[1:0];
				end
			end
			default: ;
		endcase
		rbits = rn ? -rm[W-1:0] : rm[W-1:0];
		if (err != ERR_NONE) begin
			rbits = '0; rn = 1'b0;
		end
		entry = '0;
		entry[2*W+18:2*W+16] = action;
		if (action == ACT_MUL || action == ACT_DIV) begin
			// back end takes magnitudes and sign: a magnitude in the result
			// slot, b magnitude in the low bits
			entry[2*W+15] = an ^ bn;
			entry[2*W+14:W+15] = am[W-1:0];
			entry[W+14] = am[W];
			entry[W+9] = bm[W];
			entry[W-1:0] = bm[W-1:0];
		end else begin
			entry[2*W+14:W+15] = rbits;
			entry[W+14] = rn;
			entry[W+13:W+11] = err;
			entry[W+10] = (action == ACT_CMP) & lt;
			entry[W+9]  = (action == ACT_CMP) & eq;
			entry[W+8]  = (action == ACT_CMP) & gt;
			entry[W+7:W+5] = (action == ACT_SIZE) ? ssz : 3'd0;
			entry[W+4:W+2] = (action == ACT_SIZE) ? usz : 3'd0;
			entry[W+1:W]   = (action == ACT_SIZE) ? asz : 2'd0;
		end
	end

endmodule

// ----- sv/msca_back.sv -----
// ---------------------------------------------------------------------------
// msca_back: multiply and divide sequencer plus result register
// Multiply is shift-add one bit per cycle, divide is restoring, one bit a cycle.
// ---------------------------------------------------------------------------
module msca_back #(
	parameter int W = msca_pkg::DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2*W+18:0] in_entry,
	output logic            in_ready,
	output logic            done,
	output logic [63:0]     result_value,
	output logic            result_is_signed,
	output logic [2:0]      error_code,
	output logic            is_less,
	output logic            is_equal,
	output logic            is_greater,
	output logic [2:0]      signed_size,
	output logic [2:0]      unsigned_size,
	output logic [1:0]      any_size
);
	import msca_pkg::*;

	localparam int CW = $clog2(W+2);
	localparam logic [W:0] SBIT = (W+1)'(1) << (W-1);
	localparam logic [W:0] VMAX = ((W+1)'(1) << W) - (W+1)'(1);

	bk_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic         neg_q;
	logic [W:0]   am_q, bm_q;
	logic [W+1:0] acc_q;      // product or remainder
	logic [W:0]   quo_q;
	logic         ovf_q;
	logic [W+1:0] acc_sh, rem_try;

	logic         go;
	logic [2:0]   act;
	logic [2:0]   act_q;
	logic         bz_q;

	logic [W:0]   mag;
	logic [W-1:0] bits;
	logic         rneg;
	logic [2:0]   rerr;

	assign act = in_entry[2*W+18:2*W+16];
	assign in_ready = (state_q == BK_IDLE);
	assign go = in_valid & in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (go) begin
				if (act == ACT_MUL) state_d = BK_MUL;
				else if (act == ACT_DIV) state_d = BK_DIV;
			end
			BK_MUL: if (cnt_q == '0) state_d = BK_OUT;
			BK_DIV: if (cnt_q == '0) state_d = BK_OUT;
			BK_OUT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		acc_sh = {acc_q[W:0], 1'b0};
		rem_try = {acc_q[W:0], am_q[W]} - {1'b0, bm_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (go && act != ACT_MUL && act != ACT_DIV) || (state_q == BK_OUT);
		end
	end

	always_comb begin
		mag = '0; rneg = 1'b0; rerr = ERR_NONE;
		if (act_q == ACT_MUL) begin
			mag = acc_q[W:0];
			rneg = neg_q && mag != '0;
			if (ovf_q || acc_q[W+1] || (rneg ? mag > SBIT : mag > VMAX)) rerr = ERR_MUL_OVF;
		end else begin
			mag = quo_q;
			rneg = neg_q && mag != '0;
			if (bz_q) rerr = ERR_DIV0;
			else if (rneg && mag > SBIT) rerr = ERR_QUO_OVF;
		end
		bits = rneg ? -mag[W-1:0] : mag[W-1:0];
		if (rerr != ERR_NONE) begin
			bits = '0; rneg = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			act_q <= act;
			neg_q <= in_entry[2*W+15];
			am_q  <= {in_entry[W+14], in_entry[2*W+14:W+15]};
			bm_q  <= {in_entry[W+9], in_entry[W-1:0]};
			bz_q  <= ({in_entry[W+9], in_entry[W-1:0]} == '0);
			acc_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= CW'(W);
			if (act != ACT_MUL && act != ACT_DIV) begin
				result_value     <= 64'(in_entry[2*W+14:W+15]);
				result_is_signed <= in_entry[W+14];
				error_code       <= in_entry[W+13:W+11];
				is_less          <= in_entry[W+10];
				is_equal         <= in_entry[W+9];
				is_greater       <= in_entry[W+8];
				signed_size      <= in_entry[W+7:W+5];
				unsigned_size    <= in_entry[W+4:W+2];
				any_size         <= in_entry[W+1:W];
			end
		end else if (state_q == BK_MUL) begin
			// MSB-first shift-add over W+1 bits of a; a partial sum that
			// already reaches 2^W can only grow past the range
			ovf_q <= ovf_q | acc_q[W+1] | acc_q[W];
			acc_q <= acc_sh + (am_q[W] ? {1'b0, bm_q} : '0);
			am_q <= {am_q[W-1:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end else if (state_q == BK_DIV) begin
			if (!rem_try[W+1]) begin
				acc_q <= rem_try;
				quo_q <= {quo_q[W-1:0], 1'b1};
			end else begin
				acc_q <= {acc_q[W:0], am_q[W]};
				quo_q <= {quo_q[W-1:0], 1'b0};
			end
			am_q <= {am_q[W-1:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end else if (state_q == BK_OUT) begin
			result_value     <= 64'(bits);
			result_is_signed <= rneg;
			error_code       <= rerr;
			is_less <= 1'b0; is_equal <= 1'b0; is_greater <= 1'b0;
			signed_size <= '0; unsigned_size <= '0; any_size <= '0;
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL || state_q == BK_DIV) |-> !in_ready)
		else $error("back end ready while iterating");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_OUT) |=> done)
		else $error("missing strobe after iteration");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == BK_MUL) |-> cnt_q == CW'(W))
		else $error("bad count load");

endmodule

// ----- sv/mixed_sign_checked_alu_top.sv -----
// ---------------------------------------------------------------------------
// mixed_sign_checked_alu_top: checked 64-bit mixed-sign integer ALU
// Command port in, strobed result out.
// ---------------------------------------------------------------------------
// Usage: drive action and operands with start; the item transfers on a
// rising edge with start high and busy low. Each result appears for one cycle
// with done high; the receiver cannot stall, so no result is ever held.
// The front end classifies and completes compare, add, subtract, negate and
// size classify combinationally; a two-entry queue feeds the back end.
// Those actions pass through the queue and then the result register.
// Multiply and divide iterate one bit per cycle in the back end's sequencer:
// after the queue and the operand load come DATA_WIDTH+1 bit steps, then
// the result register.
// Throughput: one simple item per cycle while the queue drains; the shared
// shift-add / restoring-divide unit sets the rate for multiply and divide.
// Reset clears the queue and the sequencer; no results are pending after it.
// ---------------------------------------------------------------------------
module mixed_sign_checked_alu_top #(
	parameter int DATA_WIDTH = msca_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [63:0] a_value,
	input  logic        a_is_signed,
	input  logic [63:0] b_value,
	input  logic        b_is_signed,
	output logic        done,
	output logic [63:0] result_value,
	output logic        result_is_signed,
	output logic [2:0]  error_code,
	output logic        is_less,
	output logic        is_equal,
	output logic        is_greater,
	output logic [2:0]  signed_size,
	output logic [2:0]  unsigned_size,
	output logic [1:0]  any_size
);
	import msca_pkg::*;

	localparam int EW = 2*DATA_WIDTH+19;

	logic [EW-1:0] f_entry;
	logic [EW-1:0] q_mem [QUEUE_DEPTH];
	logic          q_wp_q, q_rp_q;
	logic [1:0]    q_cnt_q;
	logic          b_ready, push, pop;

	msca_front #(.W(DATA_WIDTH)) u_front (
		.action(action), .a_value(a_value), .a_is_signed(a_is_signed),
		.b_value(b_value), .b_is_signed(b_is_signed), .entry(f_entry)
	);

	// hold off new commands only when the queue is full
	assign busy = (q_cnt_q == 2'(QUEUE_DEPTH));
	assign push = start & ~busy;
	assign pop  = (q_cnt_q != '0) & b_ready;

	always_ff @(posedge clk) begin
		if (push) q_mem[q_wp_q] <= f_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q <= 1'b0; q_rp_q <= 1'b0; q_cnt_q <= '0;
		end else begin
			if (push) q_wp_q <= ~q_wp_q;
			if (pop)  q_rp_q <= ~q_rp_q;
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
		end
	end

	msca_back #(.W(DATA_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_cnt_q != '0), .in_entry(q_mem[q_rp_q]), .in_ready(b_ready),
		.done(done), .result_value(result_value), .result_is_signed(result_is_signed),
		.error_code(error_code), .is_less(is_less), .is_equal(is_equal),
		.is_greater(is_greater), .signed_size(signed_size),
		.unsigned_size(unsigned_size), .any_size(any_size)
	);

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !push) else $error("push into full queue");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(q_cnt_q == '0) |-> !pop) else $error("pop from empty queue");

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb: self-checking bench for the mixed-sign checked ALU
// Drives command transfers with random gaps, predicts every result in
// sign-magnitude form and compares each strobed result as a whole struct.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import msca_pkg::*;

	localparam logic [63:0] SGN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] a_value;
		logic        a_is_signed;
		logic [63:0] b_value;
		logic        b_is_signed;
		logic [15:0] gap;
		logic        drain;
	} cmd_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic        result_is_signed;
		logic [2:0]  error_code;
		logic        is_less;
		logic        is_equal;
		logic        is_greater;
		logic [2:0]  signed_size;
		logic [2:0]  unsigned_size;
		logic [1:0]  any_size;
	} res_t;

	typedef struct {
		logic        neg;
		logic [63:0] mag;
	} smag_t;

	logic clk, arst_n, start, busy, done;
	logic [2:0] action;
	logic [63:0] a_value, b_value;
	logic a_is_signed, b_is_signed;
	res_t got;

	cmd_t pending_cmds[$];
	res_t expected_results[$];
	int mismatches = 0;
	int gap_left = 0;
	logic stim_done = 0;

	mixed_sign_checked_alu_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .a_value(a_value), .a_is_signed(a_is_signed),
		.b_value(b_value), .b_is_signed(b_is_signed), .done(done),
		.result_value(got.result_value), .result_is_signed(got.result_is_signed),
		.error_code(got.error_code), .is_less(got.is_less), .is_equal(got.is_equal),
		.is_greater(got.is_greater), .signed_size(got.signed_size),
		.unsigned_size(got.unsigned_size), .any_size(got.any_size)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Convert raw bits plus a sign flag into sign and magnitude.
	function automatic smag_t to_smag(logic [63:0] raw, logic sgn);
		smag_t r;
		if (sgn && raw[63]) begin
			r.neg = 1;
			r.mag = -raw;
			if (r.mag == 0) r.mag = SGN;
		end else begin
			r.neg = 0;
			r.mag = raw;
		end
		return r;
	endfunction

	// Checked sum; err gets too low or too high on a carry out or a negative sum past the signed minimum.
	function automatic smag_t sum_checked(smag_t x, smag_t y, output err_t err);
		smag_t r;
		logic [64:0] s;
		err = ERR_NONE;
		if (x.neg == y.neg) begin
			s = {1'b0, x.mag} + {1'b0, y.mag};
			r.neg = x.neg;
			r.mag = s[63:0];
			if (s[64] || (x.neg && s[63:0] > SGN))
				err = x.neg ? ERR_LOW : ERR_HIGH;
		end else if (x.mag >= y.mag) begin
			r.neg = x.neg;
			r.mag = x.mag - y.mag;
		end else begin
			r.neg = y.neg;
			r.mag = y.mag - x.mag;
		end
		if (r.mag == 0) r.neg = 0;
		return r;
	endfunction

	function automatic res_t predict_alu(cmd_t c);
		res_t o;
		smag_t a, b, r;
		err_t err;
		logic has_val;
		logic [127:0] p;
		o = '0;
		a = to_smag(c.a_value, c.a_is_signed);
		b = to_smag(c.b_value, c.b_is_signed);
		r.neg = 0;
		r.mag = 0;
		err = ERR_NONE;
		has_val = 1;
		case (action_t'(c.action))
			ACT_CMP: begin
				has_val = 0;
				if (a.neg != b.neg) begin
					o.is_less = a.neg;
					o.is_greater = !a.neg;
				end else if (a.mag == b.mag) begin
					o.is_equal = 1;
				end else if (!a.neg) begin
					o.is_less = a.mag < b.mag;
					o.is_greater = a.mag > b.mag;
				end else begin
					o.is_less = a.mag > b.mag;
					o.is_greater = a.mag < b.mag;
				end
			end
			ACT_ADD: r = sum_checked(a, b, err);
			ACT_SUB: begin
				if (b.mag != 0) b.neg = !b.neg;
				r = sum_checked(a, b, err);
			end
			ACT_MUL: begin
				p = a.mag * b.mag;
				r.neg = a.neg != b.neg;
				r.mag = p[63:0];
				if (r.mag == 0) r.neg = 0;
				if (p[127:64] != 0 || (r.neg && r.mag > SGN)) err = ERR_MUL_OVF;
			end
			ACT_DIV: begin
				if (b.mag == 0) begin
					err = ERR_DIV0;
				end else begin
					r.mag = a.mag / b.mag;
					r.neg = (a.neg != b.neg) && r.mag != 0;
					if (r.neg && r.mag > SGN) err = ERR_QUO_OVF;
				end
			end
			ACT_NEG: begin
				if (!a.neg && a.mag > SGN) begin
					err = ERR_NEG_OVF;
				end else begin
					r.mag = a.mag;
					r.neg = !a.neg && a.mag != 0;
				end
			end
			ACT_SIZE: begin
				has_val = 0;
				if (a.neg) begin
					o.signed_size = a.mag <= 128 ? SZ_8 : a.mag <= 32768 ? SZ_16 :
						a.mag <= 64'h8000_0000 ? SZ_32 : SZ_64;
					o.unsigned_size = SZ_NONE;
					o.any_size = o.signed_size[1:0];
				end else begin
					o.signed_size = a.mag <= 127 ? SZ_8 : a.mag <= 32767 ? SZ_16 :
						a.mag <= 64'h7FFF_FFFF ? SZ_32 : !a.mag[63] ? SZ_64 : SZ_NONE;
					o.unsigned_size = a.mag <= 255 ? SZ_8 : a.mag <= 65535 ? SZ_16 :
						a.mag <= 64'hFFFF_FFFF ? SZ_32 : SZ_64;
					o.any_size = o.unsigned_size[1:0];
				end
			end
			default: has_val = 0;
		endcase
		if (has_val) begin
			if (err != ERR_NONE) begin
				o.error_code = err;
			end else begin
				o.result_value = r.neg ? -r.mag : r.mag;
				o.result_is_signed = r.neg;
			end
		end
		return o;
	endfunction

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return ALL - $urandom_range(0, 3);
			2: return SGN + $urandom_range(0, 1) - $urandom_range(0, 1);
			3: return {{56{$urandom_range(0, 1) == 1}}, 8'($urandom)};
			4: return 64'($urandom_range(0, 300));
			5: return {32'd0, 32'($urandom)};
			6: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	function automatic logic [15:0] pick_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'd0;
			9: return 16'($urandom_range(20, 120));
			default: return 16'($urandom_range(1, 4));
		endcase
	endfunction

	task automatic queue_cmd(logic [2:0] act, logic [63:0] av, logic asg,
		logic [63:0] bv, logic bsg);
		cmd_t c;
		c.action = act;
		c.a_value = av;
		c.a_is_signed = asg;
		c.b_value = bv;
		c.b_is_signed = bsg;
		c.gap = pick_gap();
		c.drain = 0;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	initial begin
		arst_n = 0;
		// Directed: range extremes, every action, negate of signed minimum,
		// divide by zero, quotient overflow and the unused action code.
		queue_cmd(ACT_CMP, SGN, 1, ALL, 0);
		queue_cmd(ACT_CMP, ALL, 1, ALL, 1);
		queue_cmd(ACT_CMP, ALL, 0, ALL, 1);
		queue_cmd(ACT_ADD, ALL, 0, 64'd1, 0);
		queue_cmd(ACT_ADD, SGN, 1, ALL, 1);
		queue_cmd(ACT_ADD, ALL, 0, SGN, 1);
		queue_cmd(ACT_SUB, SGN, 1, 64'd1, 0);
		queue_cmd(ACT_SUB, 64'd0, 0, SGN, 0);
		queue_cmd(ACT_SUB, 64'd5, 1, 64'd5, 1);
		queue_cmd(ACT_MUL, ALL, 0, ALL, 0);
		queue_cmd(ACT_MUL, SGN, 1, 64'd1, 0);
		queue_cmd(ACT_MUL, SGN, 1, ALL, 1);
		queue_cmd(ACT_MUL, 64'd0, 0, ALL, 1);
		queue_cmd(ACT_DIV, ALL, 0, 64'd0, 1);
		queue_cmd(ACT_DIV, ALL, 0, ALL, 1);
		queue_cmd(ACT_DIV, SGN, 1, ALL, 1);
		queue_cmd(ACT_DIV, 64'd3, 1, ALL, 1);
		queue_cmd(ACT_NEG, SGN, 1, 64'd0, 0);
		queue_cmd(ACT_NEG, SGN + 64'd1, 0, 64'd0, 0);
		queue_cmd(ACT_NEG, SGN, 0, 64'd0, 0);
		queue_cmd(ACT_NEG, 64'd0, 0, 64'd0, 0);
		queue_cmd(ACT_SIZE, SGN, 1, ALL, 1);
		queue_cmd(ACT_SIZE, ALL, 0, 64'd0, 0);
		queue_cmd(ACT_SIZE, 64'hFFFF_FFFF_FFFF_FF80, 1, 64'd0, 0);
		queue_cmd(ACT_NONE, ALL, 1, ALL, 1);
		pending_cmds[$].drain = 1;
		for (int i = 0; i < 1800; i++) begin
			queue_cmd(3'($urandom_range(0, 7)), pick_operand(), 1'($urandom),
				pick_operand(), 1'($urandom));
			if (i % 500 == 250) pending_cmds[$].drain = 1;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// Driver: present the head item, hold it until it transfers, then idle for its random gap.
	// A drain item makes the sender wait until every result has come back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			action <= '0;
			a_value <= '0;
			a_is_signed <= 0;
			b_value <= '0;
			b_is_signed <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(),
					predict_alu(pending_cmds.pop_front()));
			end
			if (start && busy) begin
				// hold the current transfer
			end else if (gap_left > 0) begin
				start <= 0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() == 0) begin
				start <= 0;
				stim_done <= 1;
			end else if (pending_cmds[0].drain && (expected_results.size() != 0 ||
				(start && !busy))) begin
				start <= 0;
			end else begin
				start <= 1;
				action <= pending_cmds[0].action;
				a_value <= pending_cmds[0].a_value;
				a_is_signed <= pending_cmds[0].a_is_signed;
				b_value <= pending_cmds[0].b_value;
				b_is_signed <= pending_cmds[0].b_is_signed;
				gap_left <= pending_cmds[0].gap;
			end
		end
	end

	// Monitor: compare every strobed result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result %p", got);
			end else begin
				if (got !== expected_results[0]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected %p got %p", expected_results[0], got);
				end
				void'(expected_results.pop_front());
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_results.size() == 0);
		// drop nothing: allow a trailing multiply or divide to finish
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end
endmodule

// ----- files.f -----
sv/msca_pkg.sv
sv/msca_front.sv
sv/msca_back.sv
sv/mixed_sign_checked_alu_top.sv
tb/tb.sv
